// ----- hdl/swse_pkg.sv -----
package swse_pkg;

    localparam int SeqWidth  = 31;
    localparam int IdleWidth = 16;

    localparam logic [IdleWidth-1:0] SendIdleLimitReset    = IdleWidth'(2000);
    localparam logic [IdleWidth-1:0] ReceiveIdleLimitReset = IdleWidth'(5000);
    localparam logic [IdleWidth-1:0] IdleMax               = '1;

    // Command codes carried in the low bits of a command header.
    localparam logic [SeqWidth-1:0] CMD_CONNECT_REQ  = SeqWidth'(0);
    localparam logic [SeqWidth-1:0] CMD_CONNECT_RESP = SeqWidth'(1);
    localparam logic [SeqWidth-1:0] CMD_DISCONNECT   = SeqWidth'(2);
    localparam logic [SeqWidth-1:0] CMD_KEEPALIVE    = SeqWidth'(4);
    localparam logic [SeqWidth-1:0] CMD_ACK          = SeqWidth'(6);
    localparam logic [SeqWidth-1:0] CMD_NACK         = SeqWidth'(8);
    localparam logic [SeqWidth-1:0] CMD_ACKACK       = SeqWidth'(10);

    localparam int CMD_FLAG_BIT = 31;

    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_SEND   = 2'd2
    } t_action;

    typedef enum logic [0:0] {
        REG_SEND_IDLE_LIMIT    = 1'b0,
        REG_RECEIVE_IDLE_LIMIT = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        SEND_NONE         = 3'd0,
        SEND_CONNECT_RESP = 3'd1,
        SEND_DISCONNECT   = 3'd2,
        SEND_KEEPALIVE    = 3'd3,
        SEND_ACK          = 3'd4,
        SEND_NACK         = 3'd5,
        SEND_DATA_HEADER  = 3'd6
    } t_send_kind;

    typedef enum logic [2:0] {
        NOTE_NONE            = 3'd0,
        NOTE_CONNECTED       = 3'd1,
        NOTE_PEER_DISCONNECT = 3'd2,
        NOTE_KEEPALIVE       = 3'd3,
        NOTE_DELIVER_DATA    = 3'd4,
        NOTE_ACKED           = 3'd5,
        NOTE_SENT_DISCONNECT = 3'd6
    } t_notify;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_UNEXPECTED    = 2'd1,
        ERR_ACKACK        = 2'd2,
        ERR_UNKNOWN_CMD   = 2'd3
    } t_error_code;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] header_word;
        logic [31:0] argument_word;
    } t_in_item;

    typedef struct packed {
        t_send_kind          send_kind;
        logic [SeqWidth-1:0] send_sequence;
        t_notify             notify;
        t_error_code         error_code;
        logic                link_up;
        logic                window_open;
        logic                last;
    } t_out_item;

    // One processed item on its way into the result buffer.
    typedef struct packed {
        logic      valid;
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_push;

endpackage

// ----- hdl/swse_step.sv -----
module swse_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  swse_pkg::t_in_item i_in_data,
    output logic               o_in_stall,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_room,
    output swse_pkg::t_push    o_push
);
    import swse_pkg::*;

    logic                 r_in_valid;
    t_in_item             r_in;
    logic                 take;

    logic [IdleWidth-1:0] r_send_limit;
    logic [IdleWidth-1:0] r_recv_limit;
    logic                 r_conn;
    logic [SeqWidth-1:0]  r_rx_seq;
    logic [SeqWidth-1:0]  r_tx_seq;
    logic [IdleWidth-1:0] r_send_idle;
    logic [IdleWidth-1:0] r_recv_idle;
    logic                 r_win;

    logic                 n_conn;
    logic [SeqWidth-1:0]  n_rx_seq;
    logic [SeqWidth-1:0]  n_tx_seq;
    logic [IdleWidth-1:0] n_send_idle;
    logic [IdleWidth-1:0] n_recv_idle;
    logic                 n_win;
    t_out_item            res0;
    t_out_item            res1;
    logic                 two;

    assign take        = r_in_valid && i_room;
    assign o_in_stall  = r_in_valid && !i_room;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_limit <= SendIdleLimitReset;
            r_recv_limit <= ReceiveIdleLimitReset;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_SEND_IDLE_LIMIT:    r_send_limit <= i_cfg_data;
                REG_RECEIVE_IDLE_LIMIT: r_recv_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [SeqWidth-1:0]  code;
        logic [SeqWidth-1:0]  ack_seq;
        logic [IdleWidth-1:0] send_inc;
        logic [IdleWidth-1:0] recv_inc;
        logic                 keepalive;
        logic                 timeout;
        logic                 drop;
        t_out_item            blank;

        code     = r_in.header_word[SeqWidth-1:0];
        ack_seq  = r_in.argument_word[SeqWidth-1:0];
        send_inc = (r_send_idle == IdleMax) ? r_send_idle : r_send_idle + 1'b1;
        recv_inc = (r_recv_idle == IdleMax) ? r_recv_idle : r_recv_idle + 1'b1;
        keepalive = 1'b0;
        timeout   = 1'b0;
        drop      = 1'b0;

        blank = '{send_kind: SEND_NONE, send_sequence: '0, notify: NOTE_NONE,
                  error_code: ERR_NONE, link_up: 1'b0, window_open: 1'b0,
                  last: 1'b0};
        res0 = blank;
        res1 = blank;
        two  = 1'b0;

        n_conn      = r_conn;
        n_rx_seq    = r_rx_seq;
        n_tx_seq    = r_tx_seq;
        n_send_idle = r_send_idle;
        n_recv_idle = r_recv_idle;
        n_win       = r_win;

        unique case (t_action'(r_in.action))
            ACT_PACKET: begin
                n_recv_idle = '0;
                if (!r_in.header_word[CMD_FLAG_BIT]) begin
                    if (r_conn && code == r_rx_seq) begin
                        res0.send_kind     = SEND_ACK;
                        res0.send_sequence = r_rx_seq;
                        res0.notify        = NOTE_DELIVER_DATA;
                        n_rx_seq           = r_rx_seq + 1'b1;
                        n_send_idle        = '0;
                    end else if (r_conn && code > r_rx_seq) begin
                        res0.send_kind     = SEND_NACK;
                        res0.send_sequence = r_rx_seq;
                        n_send_idle        = '0;
                    end
                end else begin
                    unique case (code)
                        CMD_CONNECT_REQ: begin
                            drop           = 1'b1;
                            res0.send_kind = SEND_CONNECT_RESP;
                            res0.notify    = NOTE_CONNECTED;
                        end
                        CMD_CONNECT_RESP: res0.error_code = ERR_UNEXPECTED;
                        CMD_DISCONNECT: begin
                            drop        = 1'b1;
                            res0.notify = NOTE_PEER_DISCONNECT;
                        end
                        CMD_KEEPALIVE: res0.notify = NOTE_KEEPALIVE;
                        CMD_ACK: begin
                            if (ack_seq == r_tx_seq) begin
                                n_tx_seq    = r_tx_seq + 1'b1;
                                n_win       = 1'b1;
                                res0.notify = NOTE_ACKED;
                            end else if (ack_seq > r_tx_seq) begin
                                drop           = 1'b1;
                                res0.send_kind = SEND_DISCONNECT;
                                res0.notify    = NOTE_SENT_DISCONNECT;
                            end
                        end
                        CMD_NACK: begin
                            drop           = 1'b1;
                            res0.send_kind = SEND_DISCONNECT;
                            res0.notify    = NOTE_SENT_DISCONNECT;
                        end
                        CMD_ACKACK: res0.error_code = ERR_ACKACK;
                        default:    res0.error_code = ERR_UNKNOWN_CMD;
                    endcase
                end
            end
            ACT_TICK: begin
                if (r_conn) begin
                    keepalive   = send_inc > r_send_limit;
                    timeout     = recv_inc > r_recv_limit;
                    n_send_idle = keepalive ? '0 : send_inc;
                    n_recv_idle = recv_inc;
                    if (keepalive) begin
                        res0.send_kind = SEND_KEEPALIVE;
                    end
                    if (timeout) begin
                        drop = 1'b1;
                        two  = keepalive;
                        if (keepalive) begin
                            res1.send_kind = SEND_DISCONNECT;
                            res1.notify    = NOTE_SENT_DISCONNECT;
                        end else begin
                            res0.send_kind = SEND_DISCONNECT;
                            res0.notify    = NOTE_SENT_DISCONNECT;
                        end
                    end
                end
            end
            ACT_SEND: begin
                if (r_win) begin
                    n_win              = 1'b0;
                    res0.send_kind     = SEND_DATA_HEADER;
                    res0.send_sequence = r_tx_seq;
                    n_send_idle        = '0;
                end
            end
            default: ;
        endcase

        // Dropping the link clears the state and reopens the window; a connect request then comes straight back up.
        if (drop) begin
            n_conn      = (code == CMD_CONNECT_REQ) && (r_in.action == ACT_PACKET);
            n_rx_seq    = '0;
            n_tx_seq    = '0;
            n_send_idle = '0;
            n_recv_idle = '0;
            n_win       = 1'b1;
        end

        res0.link_up     = n_conn;
        res0.window_open = n_win;
        res0.last        = !two;
        res1.link_up     = n_conn;
        res1.window_open = n_win;
        res1.last        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn      <= 1'b0;
            r_rx_seq    <= '0;
            r_tx_seq    <= '0;
            r_send_idle <= '0;
            r_recv_idle <= '0;
            r_win       <= 1'b1;
        end else if (take) begin
            r_conn      <= n_conn;
            r_rx_seq    <= n_rx_seq;
            r_tx_seq    <= n_tx_seq;
            r_send_idle <= n_send_idle;
            r_recv_idle <= n_recv_idle;
            r_win       <= n_win;
        end
    end

    assign o_push = '{valid: take, two: two, first: res0, second: res1};

endmodule

// ----- hdl/swse_obuf.sv -----
module swse_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swse_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output swse_pkg::t_out_item o_out_data
);
    import swse_pkg::*;

    localparam int Depth = 4;

    t_out_item  r_mem [Depth];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       pop;
    logic [2:0] push_n;

    // Room for the largest item, two beats, counted without the pop of this cycle.
    assign o_room      = r_count <= 3'(Depth - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;
    assign push_n      = !i_push.valid ? 3'd0 : (i_push.two ? 3'd2 : 3'd1);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.first;
            if (i_push.two) begin
                r_mem[r_wr_ptr + 2'd1] <= i_push.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[1:0];
            r_rd_ptr <= r_rd_ptr + 2'(pop);
            r_count  <= r_count + push_n - 3'(pop);
        end
    end

endmodule

// ----- hdl/stop_and_wait_stream_endpoint.sv -----
// Server side of a stop-and-wait stream link. Each input beat is a received packet header
// with its second word, a one-millisecond tick, or a request to send one data packet; it
// yields one result beat, or two when a tick both sends a keep-alive and times the link out.
// An item is registered, evaluated combinationally against the link state and pushed into
// a four-entry result buffer, so a new item is taken every cycle while the buffer has room
// for two beats; the sustained rate is one item per cycle, bounded only by how fast
// results are drained. The user must write the idle limits on the configuration port
// (index 0 send, 1 receive) only while idle; the block itself does not enforce this.
module stop_and_wait_stream_endpoint (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  swse_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output swse_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import swse_pkg::*;

    t_push push;
    logic  room;

    swse_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push)
    );

    swse_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/sv/stop_and_wait_stream_endpoint_checker.sv -----
module stop_and_wait_stream_endpoint_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  swse_pkg::t_in_item            i_in_data,
    input  logic                          i_in_stall,
    input  logic                          i_out_valid,
    input  swse_pkg::t_out_item           i_out_data,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_beats_checked,
    output int                            o_paired_items,
    output logic                          o_link_up,
    output logic [swse_pkg::SeqWidth-1:0] o_receive_sequence,
    output logic [swse_pkg::SeqWidth-1:0] o_send_sequence
);
    timeunit 1ns;
    timeprecision 1ps;

    import swse_pkg::*;

    logic [IdleWidth-1:0] send_limit;
    logic [IdleWidth-1:0] receive_limit;
    logic [IdleWidth-1:0] send_idle;
    logic [IdleWidth-1:0] receive_idle;
    logic                 link_up;
    logic                 window_free;
    logic [SeqWidth-1:0]  receive_seq;
    logic [SeqWidth-1:0]  send_count;

    t_out_item reply_beats [2];
    int        reply_n;
    t_out_item expected_beats [$];

    int fail_count     = 0;
    int beats_checked  = 0;
    int paired_items   = 0;
    int pending_count  = 0;

    assign o_fail_count       = fail_count;
    assign o_pending          = pending_count;
    assign o_beats_checked    = beats_checked;
    assign o_paired_items     = paired_items;
    assign o_link_up          = link_up;
    assign o_receive_sequence = receive_seq;
    assign o_send_sequence    = send_count;

    function automatic void queue_reply(t_send_kind kind, logic [SeqWidth-1:0] seq,
                                        t_notify note, t_error_code err);
        t_out_item beat;
        beat               = '0;
        beat.send_kind     = kind;
        beat.send_sequence = seq;
        beat.notify        = note;
        beat.error_code    = err;
        reply_beats[reply_n] = beat;
        // Any packet that actually goes out restarts the send idle count.
        if (kind != SEND_NONE) begin
            send_idle = '0;
        end
        reply_n++;
    endfunction

    function automatic void drop_link();
        window_free  = 1'b1;
        receive_seq  = '0;
        send_count   = '0;
        send_idle    = '0;
        receive_idle = '0;
        link_up      = 1'b0;
    endfunction

    function automatic void send_disconnect();
        queue_reply(SEND_DISCONNECT, '0, NOTE_SENT_DISCONNECT, ERR_NONE);
        drop_link();
    endfunction

    function automatic void take_packet(logic [31:0] header, logic [31:0] argument);
        logic [SeqWidth-1:0] code;
        logic [SeqWidth-1:0] acked;
        code         = header[SeqWidth-1:0];
        acked        = argument[SeqWidth-1:0];
        receive_idle = '0;
        if (!header[CMD_FLAG_BIT]) begin
            // Data beats: in order is acknowledged, old ones are dropped, a gap is NACKed.
            if (!link_up || code < receive_seq) begin
                return;
            end
            if (code == receive_seq) begin
                queue_reply(SEND_ACK, receive_seq, NOTE_DELIVER_DATA, ERR_NONE);
                receive_seq = receive_seq + 1'b1;
            end else begin
                queue_reply(SEND_NACK, receive_seq, NOTE_NONE, ERR_NONE);
            end
            return;
        end
        case (code)
            CMD_CONNECT_REQ: begin
                drop_link();
                link_up = 1'b1;
                queue_reply(SEND_CONNECT_RESP, '0, NOTE_CONNECTED, ERR_NONE);
            end
            CMD_CONNECT_RESP: queue_reply(SEND_NONE, '0, NOTE_NONE, ERR_UNEXPECTED);
            CMD_DISCONNECT: begin
                drop_link();
                queue_reply(SEND_NONE, '0, NOTE_PEER_DISCONNECT, ERR_NONE);
            end
            CMD_KEEPALIVE: queue_reply(SEND_NONE, '0, NOTE_KEEPALIVE, ERR_NONE);
            CMD_ACK: begin
                if (acked == send_count) begin
                    send_count  = send_count + 1'b1;
                    window_free = 1'b1;
                    queue_reply(SEND_NONE, '0, NOTE_ACKED, ERR_NONE);
                end else if (acked > send_count) begin
                    send_disconnect();
                end
            end
            CMD_NACK:   send_disconnect();
            CMD_ACKACK: queue_reply(SEND_NONE, '0, NOTE_NONE, ERR_ACKACK);
            default:    queue_reply(SEND_NONE, '0, NOTE_NONE, ERR_UNKNOWN_CMD);
        endcase
    endfunction

    function automatic void take_tick();
        if (!link_up) begin
            return;
        end
        if (send_idle != IdleMax) begin
            send_idle = send_idle + 1'b1;
        end
        if (receive_idle != IdleMax) begin
            receive_idle = receive_idle + 1'b1;
        end
        if (send_idle > send_limit) begin
            queue_reply(SEND_KEEPALIVE, '0, NOTE_NONE, ERR_NONE);
        end
        if (receive_idle > receive_limit) begin
            send_disconnect();
        end
    endfunction

    function automatic void predict_replies(t_in_item item);
        reply_n = 0;
        case (item.action)
            ACT_PACKET: take_packet(item.header_word, item.argument_word);
            ACT_TICK:   take_tick();
            ACT_SEND: begin
                if (window_free) begin
                    window_free = 1'b0;
                    queue_reply(SEND_DATA_HEADER, send_count, NOTE_NONE, ERR_NONE);
                end
            end
            default: ;
        endcase
        if (reply_n == 0) begin
            queue_reply(SEND_NONE, '0, NOTE_NONE, ERR_NONE);
        end
        // Link and window flags reflect the state once the whole item is done.
        for (int k = 0; k < reply_n; k++) begin
            reply_beats[k].link_up     = link_up;
            reply_beats[k].window_open = window_free;
            reply_beats[k].last       = (k == reply_n - 1);
            expected_beats.push_back(reply_beats[k]);
        end
        if (reply_n == 2) begin
            paired_items++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            send_limit    = SendIdleLimitReset;
            receive_limit = ReceiveIdleLimitReset;
            drop_link();
            expected_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_SEND_IDLE_LIMIT) begin
                    send_limit = i_cfg_data;
                end else begin
                    receive_limit = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: %h", got);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    beats_checked++;
                    if (got.send_kind !== want.send_kind) begin
                        $error("send_kind: expected %0d, got %0d", want.send_kind,
                               got.send_kind);
                        fail_count++;
                    end
                    if (got.send_sequence !== want.send_sequence) begin
                        $error("send_sequence: expected %0d, got %0d", want.send_sequence,
                               got.send_sequence);
                        fail_count++;
                    end
                    if (got.notify !== want.notify) begin
                        $error("notify: expected %0d, got %0d", want.notify, got.notify);
                        fail_count++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d", want.error_code,
                               got.error_code);
                        fail_count++;
                    end
                    if (got.link_up !== want.link_up) begin
                        $error("link_up: expected %0d, got %0d", want.link_up, got.link_up);
                        fail_count++;
                    end
                    if (got.window_open !== want.window_open) begin
                        $error("window_open: expected %0d, got %0d", want.window_open,
                               got.window_open);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_replies(i_in_data);
            end
        end
        pending_count = expected_beats.size();
    end

endmodule

// ----- tb/sv/stop_and_wait_stream_endpoint_tb.sv -----
module stop_and_wait_stream_endpoint_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swse_pkg::*;

    localparam int         CycleLimit    = 400000;
    localparam int         ItemsPerPhase = 325;
    localparam int         PhaseCount    = 6;
    localparam logic [1:0] ActUnused     = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid;
    t_in_item  in_data;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [15:0] cfg_data;

    int                  fail_count;
    int                  pending;
    int                  beats_checked;
    int                  paired_items;
    logic                exp_link_up;
    logic [SeqWidth-1:0] exp_receive_seq;
    logic [SeqWidth-1:0] exp_send_seq;

    int cycle_count   = 0;
    int items_driven  = 0;
    bit no_gaps       = 1'b0;
    bit no_stalls     = 1'b0;
    bit hold_off_req  = 1'b0;

    always #5 i_clk = ~i_clk;

    stop_and_wait_stream_endpoint DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    stop_and_wait_stream_endpoint_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_data          (in_data),
        .i_in_stall         (in_stall),
        .i_out_valid        (out_valid),
        .i_out_data         (out_data),
        .i_out_stall        (out_stall),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_beats_checked    (beats_checked),
        .o_paired_items     (paired_items),
        .o_link_up          (exp_link_up),
        .o_receive_sequence (exp_receive_seq),
        .o_send_sequence    (exp_send_seq)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, and stall-free phases.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 119;
                out_stall <= 1'b1;
            end else if (no_stalls) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 18);
            end
        end
    end

    function automatic t_in_item packet(logic [31:0] header, logic [31:0] argument);
        t_in_item item;
        item.action        = ACT_PACKET;
        item.header_word   = header;
        item.argument_word = argument;
        return item;
    endfunction

    function automatic t_in_item command(logic [SeqWidth-1:0] code, logic [31:0] argument);
        return packet({1'b1, code}, argument);
    endfunction

    function automatic t_in_item plain(logic [1:0] action);
        t_in_item item;
        item.action        = action;
        item.header_word   = $urandom;
        item.argument_word = $urandom;
        return item;
    endfunction

    // Mostly well-formed traffic built on the predicted link state, with some noise.
    function automatic t_in_item pick_item();
        t_in_item item;
        int       roll;
        logic     junk_bit;
        roll     = $urandom_range(99);
        junk_bit = $urandom_range(1);
        if (!exp_link_up && roll < 60) begin
            item = command(CMD_CONNECT_REQ, $urandom);
        end else if (roll < 30) begin
            item = packet({1'b0, exp_receive_seq}, $urandom);
        end else if (roll < 34) begin
            item = packet({1'b0, exp_receive_seq - SeqWidth'($urandom_range(1, 3))}, $urandom);
        end else if (roll < 38) begin
            item = packet({1'b0, exp_receive_seq + SeqWidth'($urandom_range(1, 4))}, $urandom);
        end else if (roll < 56) begin
            item = plain(ACT_TICK);
        end else if (roll < 70) begin
            item = plain(ACT_SEND);
        end else if (roll < 80) begin
            item = command(CMD_ACK, {junk_bit, exp_send_seq});
        end else if (roll < 83) begin
            item = command(CMD_ACK, {junk_bit, exp_send_seq - SeqWidth'($urandom_range(1, 2))});
        end else if (roll < 85) begin
            item = command(CMD_ACK, {junk_bit, exp_send_seq + SeqWidth'($urandom_range(1, 9))});
        end else if (roll < 86) begin
            item = command(CMD_NACK, $urandom);
        end else if (roll < 87) begin
            item = command(CMD_DISCONNECT, $urandom);
        end else if (roll < 89) begin
            item = command(CMD_KEEPALIVE, $urandom);
        end else if (roll < 90) begin
            item = command(CMD_CONNECT_RESP, $urandom);
        end else if (roll < 91) begin
            item = command(CMD_ACKACK, $urandom);
        end else if (roll < 92) begin
            item = command(SeqWidth'($urandom), $urandom);
        end else if (roll < 93) begin
            item = command(CMD_CONNECT_REQ, $urandom);
        end else if (roll < 95) begin
            item = plain(ActUnused);
        end else begin
            item = plain(2'($urandom_range(3)));
        end
        return item;
    endfunction

    // Offers one beat and returns at the edge where it is taken; valid stays high after.
    task automatic drive_item(input t_in_item item);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (in_stall);
        items_driven++;
    endtask

    task automatic write_limit(input t_reg_index index, input logic [15:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] send_limits [PhaseCount];
        logic [15:0] receive_limits [PhaseCount];
        int          count;
        t_in_item    item;

        send_limits    = '{16'd0, 16'd65535, 16'd3, 16'd0, 16'd10, SendIdleLimitReset};
        receive_limits = '{16'd0, 16'd65535, 16'd6, 16'd0, 16'd2, ReceiveIdleLimitReset};
        send_limits[3]    = 16'($urandom_range(15));
        receive_limits[3] = 16'($urandom_range(30));

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through the protocol with the reset limits.
        drive_item(plain(ACT_SEND));
        drive_item(plain(ACT_SEND));
        drive_item(plain(ACT_TICK));
        drive_item(packet(32'h0000_0000, 32'h0000_0000));
        drive_item(packet(32'hFFFF_FFFF, 32'hFFFF_FFFF) | t_in_item'({ActUnused, 64'd0}));
        drive_item(command(CMD_CONNECT_REQ, 32'hFFFF_FFFF));
        drive_item(packet(32'h0000_0000, 32'hFFFF_FFFF));
        drive_item(packet(32'h0000_0000, 32'h0000_0000));
        drive_item(packet(32'h7FFF_FFFF, 32'h0000_0000));
        drive_item(plain(ACT_SEND));
        drive_item(command(CMD_ACK, 32'h8000_0000));
        drive_item(command(CMD_ACK, 32'h0000_0000));
        drive_item(command(CMD_CONNECT_RESP, 32'h0000_0000));
        drive_item(command(CMD_KEEPALIVE, 32'h0000_0000));
        drive_item(command(CMD_ACKACK, 32'h0000_0000));
        drive_item(command(SeqWidth'(3), 32'h0000_0000));
        drive_item(packet(32'hFFFF_FFFF, 32'h0000_0000));
        drive_item(plain(ACT_TICK));
        drive_item(command(CMD_ACK, 32'h0000_0005));
        drive_item(command(CMD_CONNECT_REQ, 32'h0000_0000));
        drive_item(command(CMD_NACK, 32'h0000_0000));
        drive_item(command(CMD_CONNECT_REQ, 32'h0000_0000));
        drive_item(command(CMD_DISCONNECT, 32'h0000_0000));

        for (int phase = 0; phase < PhaseCount; phase++) begin
            drain_results();
            write_limit(REG_SEND_IDLE_LIMIT, send_limits[phase]);
            write_limit(REG_RECEIVE_IDLE_LIMIT, receive_limits[phase]);
            @(negedge i_clk);
            cfg_valid <= 1'b0;
            no_gaps      = (phase == 1);
            hold_off_req = (phase == 2);
            no_stalls    = (phase == 1) || (phase == 3);
            // Bring the link up and tick once, so each limit setting is hit early.
            drive_item(command(CMD_CONNECT_REQ, $urandom));
            drive_item(plain(ACT_TICK));
            count = 0;
            while (count < ItemsPerPhase) begin
                item = pick_item();
                drive_item(item);
                if (item.action != ActUnused) begin
                    count++;
                end
            end
        end
        no_gaps   = 1'b0;
        no_stalls = 1'b0;
        drain_results();

        $display("Drove %0d items across %0d limit settings, zero and saturated included.",
                 items_driven, PhaseCount + 1);
        $display("Checked %0d result beats; %0d items answered with two beats.",
                 beats_checked, paired_items);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
